// ===== sv/hbd_pkg.sv =====
// Package of shared constants and types for the explicit-code Huffman bit decoder.
`default_nettype none

package hbd_pkg;

    localparam int HBD_MAX_NODES = 4096;

    localparam logic [15:0] HBD_OUT_LIMIT = 16'd65520;

    localparam logic [15:0] HBD_BLOCK_BYTES_RESET = 16'hFFFF;

    localparam logic [18:0] HBD_POS_MAX = 19'h7FFFF;

    typedef struct packed {
        logic [7:0] symbol;
        logic       error;
        logic       last;
    } hbd_result_t;

endpackage

`default_nettype wire

// ===== sv/hbd_in_if.sv =====
// Input channel interface carrying one code bit per transfer.
`default_nettype none

interface hbd_in_if;

    logic valid;
    logic ready;
    logic bit_in;
    logic first_of_block;

    modport source (
        output valid,
        output bit_in,
        output first_of_block,
        input  ready
    );

    modport sink (
        input  valid,
        input  bit_in,
        input  first_of_block,
        output ready
    );

endinterface

`default_nettype wire

// ===== sv/hbd_out_if.sv =====
// Output channel interface carrying one decoded symbol per transfer.
`default_nettype none

interface hbd_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       error;
    logic       last;

    modport source (
        output valid,
        output symbol,
        output error,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  symbol,
        input  error,
        input  last,
        output ready
    );

endinterface

`default_nettype wire

// ===== sv/hbd_node_mem.sv =====
// Node store: one write port and two registered read ports with write forwarding.
`default_nettype none

module hbd_node_mem #(
    parameter int  DEPTH = 4096,
    parameter int  WIDTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A write to the address being read is passed straight to the read register.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr0))
        begin
            rdata0_reg <= wdata;
        end
        else
        begin
            rdata0_reg <= mem[raddr0];
        end
        if (we && (waddr == raddr1))
        begin
            rdata1_reg <= wdata;
        end
        else
        begin
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

// ===== sv/hbd_out_stage.sv =====
// Two-entry output stage: result register plus skid register.
`default_nettype none

module hbd_out_stage
    import hbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  hbd_result_t  push_data,
    output logic         room,
    hbd_out_if.source    symbols
);

    logic        out_valid_reg;
    logic        out_valid_next;
    hbd_result_t out_data_reg;
    hbd_result_t out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    hbd_result_t skid_data_reg;
    hbd_result_t skid_data_next;
    logic        pop;

    assign pop  = out_valid_reg && symbols.ready;
    assign room = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign symbols.valid  = out_valid_reg;
    assign symbols.symbol = out_data_reg.symbol;
    assign symbols.error  = out_data_reg.error;
    assign symbols.last   = out_data_reg.last;

endmodule

`default_nettype wire

// ===== sv/explicit_code_huffman_bit_decoder_top.sv =====
// Top level of the explicit-code Huffman bit decoder.
//
// The code_bits channel takes one bit of a block per transfer, most significant bit first.
// A transfer with first_of_block set clears the code tree and all counters, and its bit is
// the first bit of the header: 256 entries of a 4-bit code length followed by the code bits.
// After the header each bit steps through the tree, and the symbols channel delivers one
// transfer for each leaf reached, or a single error transfer after which the block halts
// until the next first_of_block. The block_bytes register, written over the APB port,
// bounds the block at 8 * block_bytes bits, header included.
// One bit is taken per clock cycle while the skid register is free; a result is registered
// in the output stage. The rate is set by the node store: the entries of both children of
// the current node are read every cycle, so the next bit finds them ready.
// After reset the tree holds only the root and block_bytes is 65535; no clearing pass is run.
// The output has a result register and a skid register: while the receiver stalls, bits are
// taken until a second result is waiting, and code_bits.ready stays low while both are full.
`default_nettype none

module explicit_code_huffman_bit_decoder_top
    import hbd_pkg::*;
#(
    parameter int MAX_NODES = HBD_MAX_NODES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    hbd_in_if.sink      code_bits,
    hbd_out_if.source   symbols
);

    localparam int PW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int EW = 2 * PW + 8;

    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_CODE = 2'd1;
    localparam logic [1:0] PH_DEC  = 2'd2;
    localparam logic [1:0] PH_HALT = 2'd3;

    localparam logic REG_BLOCK_BYTES = 1'b0;

    function automatic logic [PW-1:0] left_of(input logic [EW-1:0] e);
        return e[EW-1 -: PW];
    endfunction

    function automatic logic [PW-1:0] right_of(input logic [EW-1:0] e);
        return e[EW-1-PW -: PW];
    endfunction

    function automatic logic [EW-1:0] with_child(
        input logic [EW-1:0] e,
        input logic          b,
        input logic [PW-1:0] p
    );
        logic [EW-1:0] r;
        r = e;
        if (b)
        begin
            r[EW-1-PW -: PW] = p;
        end
        else
        begin
            r[EW-1 -: PW] = p;
        end
        return r;
    endfunction

    logic [15:0]   block_bytes_reg;
    logic [1:0]    phase_reg;
    logic [1:0]    phase_next;
    logic [8:0]    sym_idx_reg;
    logic [8:0]    sym_idx_next;
    logic [3:0]    len_shift_reg;
    logic [3:0]    len_shift_next;
    logic [2:0]    len_seen_reg;
    logic [2:0]    len_seen_next;
    logic [3:0]    code_left_reg;
    logic [3:0]    code_left_next;
    logic [PW-1:0] cur_reg;
    logic [PW-1:0] cur_next;
    logic [EW-1:0] node_reg;
    logic [EW-1:0] node_next;
    logic [EW-1:0] root_reg;
    logic [EW-1:0] root_next;
    logic [NW-1:0] used_reg;
    logic [NW-1:0] used_next;
    logic [18:0]   bitpos_reg;
    logic [18:0]   bitpos_next;
    logic [15:0]   outcnt_reg;
    logic [15:0]   outcnt_next;
    logic          pend_we_reg;
    logic          pend_we_next;
    logic [PW-1:0] pend_addr_reg;
    logic [PW-1:0] pend_addr_next;
    logic [EW-1:0] pend_data_reg;
    logic [EW-1:0] pend_data_next;

    logic          accept;
    logic          room;
    logic          cfg_write;
    logic [18:0]   limit;
    logic          step_we;
    logic [PW-1:0] step_addr;
    logic [EW-1:0] step_data;
    logic          push;
    hbd_result_t   push_data;
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [EW-1:0] next_entry;
    logic [PW-1:0] rd_addr0;
    logic [PW-1:0] rd_addr1;
    logic [EW-1:0] rd_data0;
    logic [EW-1:0] rd_data1;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_BLOCK_BYTES) ? {16'd0, block_bytes_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= HBD_BLOCK_BYTES_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_BLOCK_BYTES))
        begin
            block_bytes_reg <= pwdata[15:0];
        end
    end

    assign limit  = {block_bytes_reg, 3'b000};
    assign accept = code_bits.valid && room;
    assign code_bits.ready = room;

    always_comb
    begin
        logic [EW-1:0] cur_e;
        logic [PW-1:0] chosen_ptr;
        logic [EW-1:0] chosen_e;
        logic [PW-1:0] child_ptr;
        logic [EW-1:0] child_e;
        logic          missing;
        logic          b;

        phase_next     = phase_reg;
        sym_idx_next   = sym_idx_reg;
        len_shift_next = len_shift_reg;
        len_seen_next  = len_seen_reg;
        code_left_next = code_left_reg;
        cur_next       = cur_reg;
        node_next      = node_reg;
        root_next      = root_reg;
        used_next      = used_reg;
        bitpos_next    = bitpos_reg;
        outcnt_next    = outcnt_reg;
        pend_we_next   = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_data_next = pend_data_reg;
        step_we        = 1'b0;
        step_addr      = '0;
        step_data      = '0;
        push           = 1'b0;
        push_data      = '0;
        b              = code_bits.bit_in;

        if (accept && code_bits.first_of_block)
        begin
            phase_next     = PH_LEN;
            sym_idx_next   = '0;
            len_shift_next = '0;
            len_seen_next  = '0;
            code_left_next = '0;
            cur_next       = '0;
            root_next      = '0;
            used_next      = NW'(1);
            bitpos_next    = '0;
            outcnt_next    = '0;
        end

        cur_e      = (cur_next == '0) ? root_next : node_reg;
        chosen_ptr = b ? right_of(cur_e) : left_of(cur_e);
        chosen_e   = b ? rd_data1 : rd_data0;
        // A symbol value that is written at the coming edge is not yet in the read data.
        if (pend_we_reg && (pend_addr_reg == chosen_ptr))
        begin
            chosen_e = pend_data_reg;
        end
        missing    = (chosen_ptr == '0);
        child_ptr  = chosen_ptr;
        child_e    = chosen_e;

        if (!accept || (phase_next == PH_HALT))
        begin
            phase_next = phase_next;
        end
        else if ((phase_next == PH_DEC) && (cur_next == '0) && (bitpos_next >= limit))
        begin
            phase_next = PH_HALT;
        end
        else
        begin
            if (bitpos_next != HBD_POS_MAX)
            begin
                bitpos_next = bitpos_next + 19'd1;
            end
            case (phase_next)
                PH_LEN:
                begin
                    len_shift_next = {len_shift_next[2:0], b};
                    if (len_seen_next != 3'd3)
                    begin
                        len_seen_next = len_seen_next + 3'd1;
                    end
                    else
                    begin
                        len_seen_next = '0;
                        if (len_shift_next == '0)
                        begin
                            sym_idx_next = sym_idx_next + 9'd1;
                            if (sym_idx_next[8])
                            begin
                                phase_next = PH_DEC;
                            end
                        end
                        else
                        begin
                            code_left_next = len_shift_next;
                            cur_next       = '0;
                            phase_next     = PH_CODE;
                        end
                    end
                end
                PH_CODE:
                begin
                    if (missing && (used_next >= NW'(MAX_NODES)))
                    begin
                        push             = 1'b1;
                        push_data.error  = 1'b1;
                        phase_next       = PH_HALT;
                    end
                    else
                    begin
                        if (missing)
                        begin
                            child_ptr = used_next[PW-1:0];
                            child_e   = '0;
                            used_next = used_next + NW'(1);
                            if (cur_next == '0)
                            begin
                                root_next = with_child(cur_e, b, child_ptr);
                            end
                            else
                            begin
                                step_we   = 1'b1;
                                step_addr = cur_next;
                                step_data = with_child(cur_e, b, child_ptr);
                            end
                        end
                        if (code_left_next != '0)
                        begin
                            code_left_next = code_left_next - 4'd1;
                        end
                        if (code_left_next == '0)
                        begin
                            // The node that ends the code takes the symbol value in the next
                            // cycle, when the write port is free.
                            pend_we_next   = 1'b1;
                            pend_addr_next = child_ptr;
                            pend_data_next = {child_e[EW-1:8], sym_idx_next[7:0]};
                            cur_next       = '0;
                            phase_next     = PH_LEN;
                            sym_idx_next   = sym_idx_next + 9'd1;
                            if (sym_idx_next[8])
                            begin
                                phase_next = PH_DEC;
                            end
                        end
                        else
                        begin
                            cur_next  = child_ptr;
                            node_next = child_e;
                        end
                    end
                end
                PH_DEC:
                begin
                    if (missing)
                    begin
                        push            = 1'b1;
                        push_data.error = 1'b1;
                        phase_next      = PH_HALT;
                    end
                    else if ((left_of(chosen_e) != '0) || (right_of(chosen_e) != '0))
                    begin
                        cur_next  = chosen_ptr;
                        node_next = chosen_e;
                    end
                    else
                    begin
                        cur_next = '0;
                        push     = 1'b1;
                        if (outcnt_next >= HBD_OUT_LIMIT)
                        begin
                            push_data.error = 1'b1;
                            phase_next      = PH_HALT;
                        end
                        else
                        begin
                            outcnt_next      = outcnt_next + 16'd1;
                            push_data.symbol = chosen_e[7:0];
                            push_data.last   = (bitpos_next >= limit);
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    // The children of the node that is current after this edge are read at every edge.
    assign next_entry = (cur_next == '0) ? root_next : node_next;
    assign rd_addr0   = left_of(next_entry);
    assign rd_addr1   = right_of(next_entry);

    assign mem_we    = step_we || pend_we_reg;
    assign mem_waddr = pend_we_reg ? pend_addr_reg : step_addr;
    assign mem_wdata = pend_we_reg ? pend_data_reg : step_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN;
            sym_idx_reg   <= '0;
            len_shift_reg <= '0;
            len_seen_reg  <= '0;
            code_left_reg <= '0;
            cur_reg       <= '0;
            root_reg      <= '0;
            used_reg      <= NW'(1);
            bitpos_reg    <= '0;
            outcnt_reg    <= '0;
            pend_we_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sym_idx_reg   <= sym_idx_next;
            len_shift_reg <= len_shift_next;
            len_seen_reg  <= len_seen_next;
            code_left_reg <= code_left_next;
            cur_reg       <= cur_next;
            root_reg      <= root_next;
            used_reg      <= used_next;
            bitpos_reg    <= bitpos_next;
            outcnt_reg    <= outcnt_next;
            pend_we_reg   <= pend_we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
    end

    hbd_node_mem #(
        .DEPTH (MAX_NODES),
        .WIDTH (EW)
    ) u_node_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr0 (rd_addr0),
        .raddr1 (rd_addr1),
        .rdata0 (rd_data0),
        .rdata1 (rd_data1)
    );

    hbd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .room      (room),
        .symbols   (symbols)
    );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the explicit-code Huffman bit decoder, with a scoreboard class.
`timescale 1ns / 1ps

module tb;
    import hbd_pkg::*;

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_CODE,
        PH_DECODE,
        PH_HALT
    } walk_phase_t;

    localparam logic [2:0] BLOCK_BYTES_ADDR = 3'd0;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT = 20000;

    class symbol_scoreboard;
        int unsigned left_child [HBD_MAX_NODES];
        int unsigned right_child [HBD_MAX_NODES];
        logic [7:0] node_value [HBD_MAX_NODES];
        int unsigned nodes_used;
        int unsigned symbol_index;
        int unsigned length_shift;
        int unsigned length_bits_seen;
        int unsigned code_bits_left;
        int unsigned current_node;
        int unsigned bit_position;
        int unsigned output_count;
        logic [15:0] block_bytes;
        walk_phase_t phase;
        hbd_result_t expected_symbols [$];
        int failures;

        function new();
            for (int i = 0; i < HBD_MAX_NODES; i++)
            begin
                clear_node(i);
            end
            block_bytes = HBD_BLOCK_BYTES_RESET;
            failures = 0;
            clear_block();
        endfunction

        function void clear_node(int unsigned n);
            left_child[n] = 0;
            right_child[n] = 0;
            node_value[n] = 8'd0;
        endfunction

        function void clear_block();
            clear_node(0);
            nodes_used = 1;
            phase = PH_LENGTH;
            symbol_index = 0;
            length_shift = 0;
            length_bits_seen = 0;
            code_bits_left = 0;
            current_node = 0;
            bit_position = 0;
            output_count = 0;
        endfunction

        function void next_symbol();
            symbol_index++;
            if (symbol_index >= 256)
            begin
                phase = PH_DECODE;
            end
        endfunction

        function void push_error();
            expected_symbols.push_back('{symbol: 8'd0, error: 1'b1, last: 1'b0});
            phase = PH_HALT;
        endfunction

        function void set_block_bytes(logic [15:0] value);
            block_bytes = value;
        endfunction

        function void accept_bit(logic b, logic first);
            int unsigned limit;
            int unsigned cur;
            int unsigned child;
            limit = 32'(block_bytes) * 8;
            if (first)
            begin
                clear_block();
            end
            if (phase == PH_HALT)
            begin
                return;
            end
            cur = current_node;
            if (phase == PH_DECODE && cur == 0 && bit_position >= limit)
            begin
                phase = PH_HALT;
                return;
            end
            if (bit_position < HBD_POS_MAX)
            begin
                bit_position++;
            end
            if (phase == PH_LENGTH)
            begin
                length_shift = ((length_shift << 1) | b) & 4'hF;
                if (length_bits_seen < 3)
                begin
                    length_bits_seen++;
                end
                else
                begin
                    length_bits_seen = 0;
                    if (length_shift == 0)
                    begin
                        next_symbol();
                    end
                    else
                    begin
                        code_bits_left = length_shift;
                        current_node = 0;
                        phase = PH_CODE;
                    end
                end
                return;
            end
            child = b ? right_child[cur] : left_child[cur];
            if (phase == PH_CODE)
            begin
                if (child == 0)
                begin
                    if (nodes_used >= HBD_MAX_NODES)
                    begin
                        push_error();
                        return;
                    end
                    child = nodes_used;
                    nodes_used++;
                    clear_node(child);
                    if (b)
                    begin
                        right_child[cur] = child;
                    end
                    else
                    begin
                        left_child[cur] = child;
                    end
                end
                current_node = child;
                if (code_bits_left > 0)
                begin
                    code_bits_left--;
                end
                if (code_bits_left == 0)
                begin
                    node_value[child] = 8'(symbol_index);
                    current_node = 0;
                    phase = PH_LENGTH;
                    next_symbol();
                end
                return;
            end
            if (child == 0)
            begin
                push_error();
                return;
            end
            if (left_child[child] != 0 || right_child[child] != 0)
            begin
                current_node = child;
                return;
            end
            current_node = 0;
            if (output_count >= HBD_OUT_LIMIT)
            begin
                push_error();
                return;
            end
            output_count++;
            expected_symbols.push_back('{symbol: node_value[child], error: 1'b0,
                                         last: (bit_position >= limit)});
        endfunction

        function void check_symbol(logic [7:0] sym, logic err, logic lst);
            hbd_result_t want;
            if (expected_symbols.size() == 0)
            begin
                $error("unexpected symbol transfer: symbol %0d error %0b last %0b",
                       sym, err, lst);
                failures++;
                return;
            end
            want = expected_symbols.pop_front();
            if (sym !== want.symbol)
            begin
                $error("symbol mismatch: expected %0d, got %0d", want.symbol, sym);
                failures++;
            end
            if (err !== want.error)
            begin
                $error("error mismatch: expected %0b, got %0b", want.error, err);
                failures++;
            end
            if (lst !== want.last)
            begin
                $error("last mismatch: expected %0b, got %0b", want.last, lst);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hbd_in_if  code_bits_if ();
    hbd_out_if symbols_if ();

    symbol_scoreboard sb = new();

    int cycle_count = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int src_quiet = 0;
    int snk_quiet = 0;
    int blk_bits = 0;

    logic [3:0]  code_len [256];
    logic [14:0] code_word [256];
    int          leaf_len [$];
    int          leaf_word [$];
    logic        header_q [$];

    explicit_code_huffman_bit_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .code_bits (code_bits_if),
        .symbols   (symbols_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        if (rst_n && symbols_if.valid && symbols_if.ready)
        begin
            sb.check_symbol(symbols_if.symbol, symbols_if.error, symbols_if.last);
        end
    end

    initial
    begin
        symbols_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (snk_quiet > 0)
            begin
                snk_quiet--;
            end
            else if ($urandom_range(0, 299) == 0)
            begin
                snk_quiet = $urandom_range(30, 150);
            end
            symbols_if.ready = !(snk_quiet == 0 && $urandom_range(0, 99) < snk_stall_pct);
        end
    end

    task automatic send_bit(input logic b, input logic first);
        if (src_quiet > 0)
        begin
            src_quiet--;
        end
        else if ($urandom_range(0, 299) == 0)
        begin
            src_quiet = $urandom_range(30, 150);
        end
        while (src_quiet == 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            @(negedge clk);
            code_bits_if.valid = 1'b0;
        end
        @(negedge clk);
        code_bits_if.valid = 1'b1;
        code_bits_if.bit_in = b;
        code_bits_if.first_of_block = first;
        do
        begin
            @(posedge clk);
        end
        while (!code_bits_if.ready);
        sb.accept_bit(b, first);
        blk_bits = first ? 1 : blk_bits + 1;
    endtask

    task automatic send_code_word(input int len, input int word);
        for (int i = len - 1; i >= 0; i--)
        begin
            send_bit((word >> i) & 1, 1'b0);
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (addr == BLOCK_BYTES_ADDR)
        begin
            sb.set_block_bytes(data[15:0]);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        code_bits_if.valid = 1'b0;
        while (sb.expected_symbols.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void clear_code();
        for (int s = 0; s < 256; s++)
        begin
            code_len[s] = 4'd0;
            code_word[s] = 15'd0;
        end
        leaf_len.delete();
        leaf_word.delete();
    endfunction

    function automatic void fill_header();
        header_q.delete();
        for (int s = 0; s < 256; s++)
        begin
            for (int i = 3; i >= 0; i--)
            begin
                header_q.push_back(code_len[s][i]);
            end
            for (int i = int'(code_len[s]) - 1; i >= 0; i--)
            begin
                header_q.push_back(code_word[s][i]);
            end
        end
    endfunction

    task automatic send_header_bits(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_bit(header_q[i], i == 0);
        end
    endtask

    function automatic void build_random_code(input int leaves, input bit messy,
                                              input bit drop_one);
        int perm [256];
        int idx;
        int tmp;
        int tries;
        int s;
        int len;
        clear_code();
        for (int i = 0; i < 256; i++)
        begin
            perm[i] = i;
        end
        for (int i = 255; i > 0; i--)
        begin
            idx = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[idx];
            perm[idx] = tmp;
        end
        leaf_len = '{1, 1};
        leaf_word = '{0, 1};
        tries = 0;
        while (leaf_len.size() < leaves && tries < 1000)
        begin
            tries++;
            idx = $urandom_range(0, leaf_len.size() - 1);
            if (leaf_len[idx] < 15)
            begin
                leaf_len.push_back(leaf_len[idx] + 1);
                leaf_word.push_back(leaf_word[idx] * 2 + 1);
                leaf_len[idx] = leaf_len[idx] + 1;
                leaf_word[idx] = leaf_word[idx] * 2;
            end
        end
        if (drop_one)
        begin
            idx = $urandom_range(0, leaf_len.size() - 1);
            leaf_len.delete(idx);
            leaf_word.delete(idx);
        end
        for (int i = 0; i < leaf_len.size(); i++)
        begin
            code_len[perm[i]] = 4'(leaf_len[i]);
            code_word[perm[i]] = 15'(leaf_word[i]);
        end
        if (messy)
        begin
            for (int j = 0; j < int'($urandom_range(1, 4)); j++)
            begin
                s = perm[leaf_len.size() + j];
                idx = $urandom_range(0, leaf_len.size() - 1);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        code_len[s] = 4'($urandom_range(1, 15));
                        code_word[s] = 15'($urandom);
                    end
                    1:
                    begin
                        code_len[s] = 4'(leaf_len[idx]);
                        code_word[s] = 15'(leaf_word[idx]);
                    end
                    default:
                    begin
                        len = (leaf_len[idx] > 1) ? $urandom_range(1, leaf_len[idx] - 1) : 1;
                        code_len[s] = 4'(len);
                        code_word[s] = 15'(leaf_word[idx] >> (leaf_len[idx] - len));
                    end
                endcase
            end
        end
    endfunction

    task automatic send_symbols(input int count, input int noise_pct);
        int idx;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                send_bit($urandom_range(0, 1), 1'b0);
            end
            else
            begin
                idx = $urandom_range(0, leaf_len.size() - 1);
                send_code_word(leaf_len[idx], leaf_word[idx]);
            end
        end
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int count);
        settle();
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        send_symbols(count, ($urandom_range(0, 1) == 0) ? 0 : 5);
    endtask

    initial
    begin
        int guard;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = BLOCK_BYTES_ADDR;
        pwdata = 32'd0;
        code_bits_if.valid = 1'b0;
        code_bits_if.bit_in = 1'b0;
        code_bits_if.first_of_block = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        apb_write(BLOCK_BYTES_ADDR, {16'd0, 16'hFFFF});

        build_random_code($urandom_range(8, 24), $urandom_range(0, 3) == 0, 1'b0);
        fill_header();

        // Two header starts are cut short by a new block before the full header follows.
        for (int i = 0; i < 2; i++)
        begin
            send_header_bits($urandom_range(20, 60));
        end
        send_header_bits(header_q.size());
        send_symbols(20, 0);

        run_phase(77, 0, 15);
        run_phase(0, 77, 15);
        run_phase(30, 30, 15);

        // The bit limit is set a little ahead, so a symbol completes past it and later
        // bits are ignored.
        settle();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        apb_write(BLOCK_BYTES_ADDR, 32'((blk_bits + 40) / 8));
        send_symbols(25, 0);

        @(negedge clk);
        code_bits_if.valid = 1'b0;
        guard = 0;
        while (sb.expected_symbols.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (sb.expected_symbols.size() != 0)
        begin
            $error("%0d expected symbol transfers never arrived", sb.expected_symbols.size());
            sb.failures++;
        end
        if (sb.failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hbd_pkg.sv
sv/hbd_in_if.sv
sv/hbd_out_if.sv
sv/hbd_node_mem.sv
sv/hbd_out_stage.sv
sv/explicit_code_huffman_bit_decoder_top.sv
test/tb.sv
